/* design/stereo_vibrato_delay_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef STEREO_VIBRATO_DELAY_CORE_ASSERT_SVH
`define STEREO_VIBRATO_DELAY_CORE_ASSERT_SVH

// Check a property outside reset.
`define SVD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/svd_pkg.sv */
package svd_pkg;

	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned KNOB_W = 16;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_RATE_KNOB = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WET_LEVEL = 2'd1;

	localparam logic [15:0] RATE_KNOB_RESET = 16'd32768;
	localparam logic [15:0] WET_LEVEL_RESET = 16'd65535;
	localparam logic [15:0] DRIFT_RESET = 16'd32768;
	localparam logic [15:0] RESEED_BASE = 16'd28147;
	localparam logic [20:0] RESEED_GAIN = 21'd17395;
	localparam logic [20:0] PHASE_STEP_GAIN = 21'd683565;
	localparam logic [31:0] SEED_LEFT = 32'h2545F491;
	localparam logic [31:0] SEED_RIGHT = 32'h9E3779B9;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// sin(j / 2^qbits * pi/2) in Q1.15, Taylor series in Q2.30
	function automatic logic [16:0] quarter_sine(input longint unsigned j,
			input int unsigned qbits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned r;
		longint sum;
		x = (j * HALF_PI_Q30) >> qbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 6; k++) begin
			term = (term * x2) >> 30;
			case (k)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				default: term = term / 156;
			endcase
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
		r = (longint'(sum) + 64'd16384) >> 15;
		return r[16:0];
	endfunction

endpackage

/* design/stereo_vibrato_delay_core.sv */
// Stereo vibrato delay core.
// Each input beat steps through the states K2, K3, DR, GN, PH, RS, SIN, OFF, RED, RA, RB,
// M0 to M8 and OUT; RED is held once more for each wrap of a read index past the end
// of the store (more than one wrap is possible at small store sizes). The next beat is
// taken once the result sits in the output register, and a stalled full output register
// holds the core. Reset: delay stores read as zero until written (fill count), LFO and
// noise return to their seeds; no clearing pass.
module stereo_vibrato_delay_core
	import svd_pkg::*;
#(
	parameter int MAX_DELAY_INDEX = 256,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	input  logic                       cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [KNOB_W-1:0]          cfg_wdata
);

	localparam int DEPTH = MAX_DELAY_INDEX + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int SW = ((AW > 8) ? AW : 8) + 1;
	localparam int SB = SINE_TABLE_BITS;
	localparam int QB = SINE_TABLE_BITS - 2;
	localparam int QUARTER = 1 << QB;

	typedef enum logic [4:0] {
		ST_IDLE, ST_K2, ST_K3, ST_DR, ST_GN, ST_PH, ST_RS, ST_SIN, ST_OFF,
		ST_RED, ST_RA, ST_RB, ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
		ST_M6, ST_M7, ST_M8, ST_OUT
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic [AW-1:0] wi_q;
	logic [FW-1:0] fill_q;
	logic [31:0] phase_q;
	logic [15:0] drift_q;
	logic [31:0] noise_l_q;
	logic [31:0] noise_r_q;
	logic wrap_q;
	logic [15:0] rate_q;
	logic [15:0] wet_q;

	logic signed [SAMPLE_W-1:0] dry_q [2];
	logic signed [16:0] sin_q [2];
	logic [14:0] frac_q [2];
	logic [SW-1:0] sum_q [2];
	logic va_q [2];
	logic vb_q [2];
	logic signed [SAMPLE_W-1:0] a_q [2];
	logic signed [SAMPLE_W-1:0] b_q [2];
	logic signed [SAMPLE_W-1:0] wetv_q [2];
	logic signed [SAMPLE_W-1:0] mix_q [2];
	logic signed [SAMPLE_W-1:0] left_out_q;
	logic signed [SAMPLE_W-1:0] right_out_q;
	logic signed [53:0] prod_q;
	logic signed [53:0] acc_q;

	logic signed [32:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [53:0] prod_d;
	logic signed [53:0] isum;
	logic signed [53:0] msum;
	logic signed [SAMPLE_W-1:0] mix_d;
	logic [32:0] phase_sum;
	logic out_load;
	logic [SB-1:0] sidx [2];
	logic [16:0] qtab [QUARTER+1];
	logic signed [16:0] sin_d [2];
	logic [22:0] off_d [2];
	logic [SAMPLE_W-1:0] rdata [2];
	logic [AW-1:0] raddr [2];

	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [37:0] v);
		if (v > 38'sd8388607) return 24'sh7FFFFF;
		if (v < -38'sd8388608) return 24'sh800000;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
		assign qtab[g] = quarter_sine(64'(g), QB);
	end

	for (genvar c = 0; c < 2; c++) begin : g_lane
		svd_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_store (
			.clk  (clk),
			.we   (state_q == ST_K2),
			.waddr(wi_q),
			.wdata(dry_q[c]),
			.raddr(raddr[c]),
			.rdata(rdata[c])
		);
		assign raddr[c] = sum_q[c][AW-1:0];
	end

	assign sidx[0] = phase_q[31 -: SB];
	assign sidx[1] = sidx[0] + SB'(QUARTER);

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			logic [1:0] quad;
			logic [QB:0] j;
			logic [QB:0] ti;
			logic [16:0] v;
			logic [16:0] u;
			quad = sidx[c][SB-1 -: 2];
			j = {1'b0, sidx[c][QB-1:0]};
			ti = quad[0] ? ((QB+1)'(QUARTER) - j) : j;
			v = qtab[ti];
			sin_d[c] = quad[1] ? $signed(17'd0 - v) : $signed(v);
			u = sin_q[c] + 17'h08000;
			off_d[c] = 23'(u) * 23'd127;
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_K2: begin
				mul_a = {17'd0, rate_q};
				mul_b = {5'd0, rate_q};
			end
			ST_K3: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = {5'd0, rate_q};
			end
			ST_DR: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = {5'd0, drift_q};
			end
			ST_GN: begin
				mul_a = {17'd0, prod_q[31:16]};
				mul_b = PHASE_STEP_GAIN;
			end
			ST_PH: begin
				mul_a = {1'b0, noise_l_q};
				mul_b = RESEED_GAIN;
			end
			ST_M0: begin
				mul_a = 33'(a_q[0]);
				mul_b = {5'd0, 16'(17'd32768 - {2'd0, frac_q[0]})};
			end
			ST_M1: begin
				mul_a = 33'(b_q[0]);
				mul_b = {6'd0, frac_q[0]};
			end
			ST_M2: begin
				mul_a = 33'(a_q[1]);
				mul_b = {5'd0, 16'(17'd32768 - {2'd0, frac_q[1]})};
			end
			ST_M3: begin
				mul_a = 33'(b_q[1]);
				mul_b = {6'd0, frac_q[1]};
			end
			ST_M4: begin
				mul_a = 33'(wetv_q[0]);
				mul_b = {5'd0, wet_q};
			end
			ST_M5: begin
				mul_a = 33'(dry_q[0]);
				mul_b = {3'd0, 18'(18'h10000 - {2'd0, wet_q})};
			end
			ST_M6: begin
				mul_a = 33'(wetv_q[1]);
				mul_b = {5'd0, wet_q};
			end
			ST_M7: begin
				mul_a = 33'(dry_q[1]);
				mul_b = {3'd0, 18'(18'h10000 - {2'd0, wet_q})};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign isum = acc_q + prod_q + 54'sd16384;
	assign msum = acc_q + prod_q + 54'sd32768;
	assign mix_d = sat24(msum[53:16]);
	assign phase_sum = {1'b0, phase_q} + 33'(prod_q[35:16]);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			wi_q <= '0;
			fill_q <= '0;
			phase_q <= '0;
			drift_q <= DRIFT_RESET;
			noise_l_q <= SEED_LEFT;
			noise_r_q <= SEED_RIGHT;
			wrap_q <= 1'b0;
			rate_q <= RATE_KNOB_RESET;
			wet_q <= WET_LEVEL_RESET;
		end else begin
			if (cfg_wr_en && cfg_index == REG_RATE_KNOB) rate_q <= cfg_wdata;
			if (cfg_wr_en && cfg_index == REG_WET_LEVEL) wet_q <= cfg_wdata;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_K2;
				ST_K2: begin
					wi_q <= (wi_q == AW'(DEPTH - 1)) ? '0 : wi_q + 1'b1;
					if (fill_q != FW'(DEPTH)) fill_q <= fill_q + 1'b1;
					state_q <= ST_K3;
				end
				ST_K3: state_q <= ST_DR;
				ST_DR: state_q <= ST_GN;
				ST_GN: state_q <= ST_PH;
				ST_PH: begin
					wrap_q <= phase_sum[32];
					phase_q <= phase_sum[32] ? '0 : phase_sum[31:0];
					state_q <= ST_RS;
				end
				ST_RS: begin
					if (wrap_q) drift_q <= RESEED_BASE + prod_q[47:32];
					state_q <= ST_SIN;
				end
				ST_SIN: state_q <= ST_OFF;
				ST_OFF: state_q <= ST_RED;
				ST_RED: begin
					if (sum_q[0] < SW'(DEPTH) && sum_q[1] < SW'(DEPTH)) state_q <= ST_RA;
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: state_q <= ST_M0;
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: state_q <= ST_M6;
				ST_M6: state_q <= ST_M7;
				ST_M7: state_q <= ST_M8;
				ST_M8: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						noise_l_q <= xorshift(noise_l_q);
						noise_r_q <= xorshift(noise_r_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (state_q == ST_IDLE && in_valid) begin
			dry_q[0] <= left_sample;
			dry_q[1] <= right_sample;
		end
		for (int c = 0; c < 2; c++) begin
			if (state_q == ST_SIN) sin_q[c] <= sin_d[c];
			if (state_q == ST_OFF) begin
				frac_q[c] <= off_d[c][14:0];
				sum_q[c] <= SW'(wi_q) + SW'(off_d[c][22:15]);
			end
			if (state_q == ST_RED && sum_q[c] >= SW'(DEPTH)) sum_q[c] <= sum_q[c] - SW'(DEPTH);
			if (state_q == ST_RA) begin
				va_q[c] <= sum_q[c] < SW'(fill_q);
				sum_q[c] <= (sum_q[c] == SW'(DEPTH - 1)) ? '0 : sum_q[c] + 1'b1;
			end
			if (state_q == ST_RB) begin
				a_q[c] <= va_q[c] ? $signed(rdata[c]) : '0;
				vb_q[c] <= sum_q[c] < SW'(fill_q);
			end
			if (state_q == ST_M0) b_q[c] <= vb_q[c] ? $signed(rdata[c]) : '0;
		end
		if (state_q == ST_M0 || state_q == ST_M2 || state_q == ST_M4 || state_q == ST_M6)
			acc_q <= prod_q;
		if (state_q == ST_M1 || state_q == ST_M3 || state_q == ST_M5 || state_q == ST_M7)
			acc_q <= prod_q;
		if (state_q == ST_M2) wetv_q[0] <= isum[38:15];
		if (state_q == ST_M4) wetv_q[1] <= isum[38:15];
		if (state_q == ST_M6) mix_q[0] <= (wet_q == WET_LEVEL_RESET) ? wetv_q[0] : mix_d;
		if (state_q == ST_M8) mix_q[1] <= (wet_q == WET_LEVEL_RESET) ? wetv_q[1] : mix_d;
		if (out_load) begin
			left_out_q <= mix_q[0];
			right_out_q <= mix_q[1];
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign left_out = left_out_q;
	assign right_out = right_out_q;

endmodule

/* design/svd_ram.sv */
module svd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* design/svd_checker.sv */
`include "stereo_vibrato_delay_core_assert.svh"

module svd_checker
	import svd_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic signed [SAMPLE_W-1:0] left_out,
	input logic signed [SAMPLE_W-1:0] right_out
);

	`SVD_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> (!out_valid && !in_stall), "busy in reset")

	`SVD_ASSERT(a_busy_after_beat, clk, arst_n, (in_valid && !in_stall) |=> in_stall, "no stall after input beat")

	`SVD_ASSERT(a_no_early_result, clk, arst_n, (in_valid && !in_stall && !out_valid) |=> !out_valid, "result one cycle after input beat")

	`SVD_ASSERT(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(left_out) && $stable(right_out)), "stalled output beat changed")

endmodule

bind stereo_vibrato_delay_core svd_checker u_svd_checker (.*);
